@@ hw/rtl/msort_pkg.sv @@
package msort_pkg;

    // element width and default store depth
    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 32;

    typedef logic signed [DATA_W-1:0] t_data;

endpackage

@@ hw/rtl/msort_in_if.sv @@
interface msort_in_if;
    import msort_pkg::*;

    logic  valid;
    logic  ready;
    t_data value;
    logic  final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);

endinterface

@@ hw/rtl/msort_out_if.sv @@
interface msort_out_if;
    import msort_pkg::*;

    logic  valid;
    logic  ready;
    t_data sorted_value;
    logic  final_result;
    logic  overflow;

    modport source (output valid, output sorted_value, output final_result,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input final_result,
                    input overflow, output ready);

endinterface

@@ hw/rtl/msort_ram.sv @@
module msort_ram #(
    parameter int CAPACITY = msort_pkg::CAPACITY_DEF,
    parameter int AW       = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_wbank,
    input  logic [AW-1:0]    i_waddr,
    input  msort_pkg::t_data i_wdata,
    input  logic             i_rbank,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output msort_pkg::t_data o_rdata_a,
    output msort_pkg::t_data o_rdata_b
);
    import msort_pkg::*;

    // two banks: element store and merge scratch, swapped on every pass
    t_data r_mem [2][CAPACITY];
    t_data r_rdata_a;
    t_data r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wbank][i_waddr] <= i_wdata;
        end
    end

    // two registered read ports on the same bank
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_rbank][i_raddr_a];
        r_rdata_b <= r_mem[i_rbank][i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hw/rtl/merge_sorter_core.sv @@
// Loading: one element per cycle, ready whenever the block is idle.
// Sorting n elements: ceil(log2 n) merge passes; each pass reads and writes every element
// through the shared compare unit and two-port store, with a setup step before each merge.
// Emitting: each result is read from the store, then loaded into the output register once
// the register is empty or the sink takes the result it holds.
// Reset (synchronous, active low) returns to idle and clears fill count, overflow flag and output valid.
module merge_sorter_core #(
    parameter int CAPACITY = msort_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msort_in_if.sink    i_item,
    msort_out_if.source o_result
);
    import msort_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MERGE_RD,
        S_MERGE_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_src;
    logic [PW-1:0] r_n;
    logic [PW-1:0] r_width;
    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_mid;
    logic [PW-1:0] r_hi;
    logic [PW-1:0] r_i;
    logic [PW-1:0] r_j;
    logic [PW-1:0] r_k;
    logic          r_out_valid;
    t_data         r_out_value;
    logic          r_out_final;
    logic          r_out_ovf;

    logic          in_fire;
    logic          out_fire;
    logic          room;
    logic [PW-1:0] n_count;
    logic [PW-1:0] mid_raw;
    logic [PW-1:0] hi_raw;
    logic [PW-1:0] n_mid;
    logic [PW-1:0] n_hi;
    logic [PW-1:0] n_lo;
    logic [PW-1:0] n_width;
    logic          take_left;
    logic          run_done;
    logic          last_out;
    logic          out_load;
    logic          emitting;
    t_data         rd_a;
    t_data         rd_b;
    logic          we;
    logic          wbank;
    logic [AW-1:0] waddr;
    t_data         wdata;

    // handshake
    assign i_item.ready          = (r_state == S_IDLE);
    assign in_fire               = i_item.valid && i_item.ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.sorted_value = r_out_value;
    assign o_result.final_result = r_out_final;
    assign o_result.overflow     = r_out_ovf;
    assign out_fire              = r_out_valid && o_result.ready;

    // fill count after the current transaction
    assign room    = (r_count < CAP_C);
    assign n_count = PW'(r_count) + PW'(room);

    // run bounds, clamped to the set size
    assign mid_raw = r_lo + r_width;
    assign hi_raw  = r_lo + (r_width << 1);
    assign n_mid   = (mid_raw > r_n) ? r_n : mid_raw;
    assign n_hi    = (hi_raw > r_n) ? r_n : hi_raw;
    assign n_lo    = hi_raw;
    assign n_width = r_width << 1;

    // shared compare: left run wins on ties
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || (rd_a <= rd_b));
    assign run_done  = ((r_k + PW'(1)) == r_hi);
    assign last_out  = ((r_k + PW'(1)) == r_n);
    assign out_load  = (r_state == S_EMIT_LD) && (!r_out_valid || out_fire);
    assign emitting  = (r_state == S_EMIT_RD) || (r_state == S_EMIT_LD);

    // store write port: load into bank zero, merge into the other bank
    always_comb begin
        we    = 1'b0;
        wbank = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = i_item.value;
        if (r_state == S_MERGE_WR) begin
            we    = 1'b1;
            wbank = ~r_src;
            waddr = r_k[AW-1:0];
            wdata = take_left ? rd_a : rd_b;
        end else if (in_fire && room) begin
            we = 1'b1;
        end
    end

    msort_ram #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wbank   (wbank),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_rbank   (r_src),
        .i_raddr_a (emitting ? r_k[AW-1:0] : r_i[AW-1:0]),
        .i_raddr_b (r_j[AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // sequencer: load, merge passes, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output once taken, unless the next result replaces it
            if (out_fire && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.final_item) begin
                            r_n     <= n_count;
                            r_src   <= 1'b0;
                            r_width <= PW'(1);
                            r_lo    <= '0;
                            r_k     <= '0;
                            r_state <= (n_count > PW'(1)) ? S_SETUP : S_EMIT_RD;
                        end
                    end
                end
                S_SETUP: begin
                    r_mid   <= n_mid;
                    r_hi    <= n_hi;
                    r_i     <= r_lo;
                    r_j     <= n_mid;
                    r_k     <= r_lo;
                    r_state <= S_MERGE_RD;
                end
                S_MERGE_RD: begin
                    r_state <= S_MERGE_WR;
                end
                S_MERGE_WR: begin
                    if (take_left) begin
                        r_i <= r_i + PW'(1);
                    end else begin
                        r_j <= r_j + PW'(1);
                    end
                    if (!run_done) begin
                        r_k     <= r_k + PW'(1);
                        r_state <= S_MERGE_RD;
                    end else if (n_lo < r_n) begin
                        r_lo    <= n_lo;
                        r_state <= S_SETUP;
                    end else begin
                        // pass complete: swap banks, double the run width
                        r_src   <= ~r_src;
                        r_width <= n_width;
                        r_lo    <= '0;
                        if (n_width < r_n) begin
                            r_state <= S_SETUP;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= rd_a;
                        r_out_final <= last_out;
                        r_out_ovf   <= r_ovf;
                        if (last_out) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + PW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count beyond store depth");

    // merge write index stays inside the current run
    a_k_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE_WR) |-> ((r_k >= r_lo) && (r_k < r_hi)))
        else $error("merge write index outside run");

    // every element written so far came from exactly one of the two runs
    a_merge_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE_WR) |-> ((r_k + r_mid) == (r_i + r_j)))
        else $error("merge pointers out of step");

    // the last result of a set returns the block to an empty idle state
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && last_out) |=> ((r_state == S_IDLE) && (r_count == '0) && !r_ovf))
        else $error("set not cleared after last result");

endmodule

@@ tb/msort_checker.sv @@
module msort_checker #(
    parameter int CAPACITY = msort_pkg::CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    msort_in_if  i_item,
    msort_out_if i_result,
    output int   o_fail_count,
    output int   o_pending
);
    import msort_pkg::*;

    typedef struct {
        t_data value;
        logic  last;
        logic  overflow;
    } sorted_result_t;

    // set being gathered, and the results still owed to the sink
    t_data          set_store [CAPACITY];
    t_data          merge_buf [CAPACITY];
    int             set_fill;
    logic           set_dropped;
    sorted_result_t sorted_due_q [$];
    int             fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
        set_fill     = 0;
        set_dropped  = 1'b0;
    end

    task automatic report_mismatch(input string what, input t_data got, input t_data want);
        fail_total++;
        $display("%0t: %0s mismatch, got %0d, want %0d", $time, what, got, want);
    endtask

    // Stable bottom-up merge over the first n entries; ties keep the left run first
    function automatic void merge_sort_set(input int n);
        int width, lo, mid, hi, i, j, k;
        for (width = 1; width < n; width = width * 2) begin
            for (lo = 0; lo + width < n; lo = lo + 2 * width) begin
                mid = lo + width;
                hi  = (mid + width > n) ? n : mid + width;
                i   = lo;
                j   = mid;
                for (k = lo; k < hi; k++) begin
                    if (j >= hi || (i < mid && set_store[i] <= set_store[j])) begin
                        merge_buf[k] = set_store[i];
                        i++;
                    end else begin
                        merge_buf[k] = set_store[j];
                        j++;
                    end
                end
                for (k = lo; k < hi; k++) begin
                    set_store[k] = merge_buf[k];
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        sorted_result_t due;
        int k;
        if (!i_rst_n) begin
            set_fill    = 0;
            set_dropped = 1'b0;
            sorted_due_q.delete();
        end else begin
            // compare each result transaction with the oldest one owed
            if (i_result.valid && i_result.ready) begin
                if (sorted_due_q.size() == 0) begin
                    report_mismatch("unexpected result", i_result.sorted_value, '0);
                end else begin
                    due = sorted_due_q.pop_front();
                    if (i_result.sorted_value !== due.value)
                        report_mismatch("sorted_value", i_result.sorted_value, due.value);
                    if (i_result.final_result !== due.last)
                        report_mismatch("final_result", t_data'(i_result.final_result),
                                        t_data'(due.last));
                    if (i_result.overflow !== due.overflow)
                        report_mismatch("overflow", t_data'(i_result.overflow),
                                        t_data'(due.overflow));
                end
            end
            // store or drop the item; on the last one sort and queue the whole set
            if (i_item.valid && i_item.ready) begin
                if (set_fill < CAPACITY) begin
                    set_store[set_fill] = i_item.value;
                    set_fill++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_item.final_item) begin
                    merge_sort_set(set_fill);
                    for (k = 0; k < set_fill; k++) begin
                        due.value    = set_store[k];
                        due.last     = (k == set_fill - 1);
                        due.overflow = set_dropped;
                        sorted_due_q.push_back(due);
                    end
                    set_fill    = 0;
                    set_dropped = 1'b0;
                end
            end
        end
        o_pending    <= sorted_due_q.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/merge_sorter_core_tb.sv @@
module merge_sorter_core_tb;
    import msort_pkg::*;

    localparam int    CAPACITY     = CAPACITY_DEF;
    localparam int    RANDOM_ITEMS = 350;
    localparam int    HOLD_CYCLES  = 600;
    localparam int    DRAIN_CYCLES = 400;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    IDLE_PCT     = 34;
    localparam t_data DATA_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum int {
        VAL_WIDE,
        VAL_CLUSTERED,
        VAL_EDGES
    } value_mix_e;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    bit   in_idle_en  = 1'b1;
    bit   out_idle_en = 1'b1;
    bit   hold_req    = 1'b0;
    int   hold_left   = 0;

    msort_in_if  item_ch ();
    msort_out_if result_ch ();

    merge_sorter_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    msort_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a run that passes the cycle limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sink side: random back-pressure or always ready, or a long hold-off when requested
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end else if (out_idle_en) begin
            result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    function automatic t_data pick_value(input value_mix_e mix);
        case (mix)
            VAL_WIDE:      return t_data'($urandom);
            VAL_CLUSTERED: return t_data'($urandom_range(0, 15)) - t_data'(8);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return DATA_MAX;
                    1:       return DATA_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return t_data'($urandom);
                endcase
            end
        endcase
    endfunction

    // Offer one item after an optional random gap and hold it until the transaction
    task automatic drive_item(input t_data v, input logic last);
        @(negedge clk);
        while (in_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.value      <= v;
        item_ch.final_item <= last;
        do begin
            @(posedge clk);
        end while (!(item_ch.valid && item_ch.ready));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        int         set_idx;
        int         sent;
        int         len;
        int         k;
        int         roll;
        value_mix_e mix;

        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.value      = '0;
        item_ch.final_item = 1'b0;
        result_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-element sets at both extremes
        drive_item(DATA_MAX, 1'b1);
        drive_item(DATA_MIN, 1'b1);
        // extremes mixed with duplicates around zero
        drive_item('0, 1'b0);
        drive_item('1, 1'b0);
        drive_item(DATA_MAX, 1'b0);
        drive_item(DATA_MIN, 1'b0);
        drive_item(t_data'(1), 1'b0);
        drive_item('1, 1'b1);
        // descending input, odd length
        drive_item(t_data'(3), 1'b0);
        drive_item(t_data'(2), 1'b0);
        drive_item(t_data'(1), 1'b1);
        // all equal
        drive_item(t_data'(-5), 1'b0);
        drive_item(t_data'(-5), 1'b0);
        drive_item(t_data'(-5), 1'b1);
        // already ascending, even length
        drive_item(DATA_MIN, 1'b0);
        drive_item(t_data'(-2), 1'b0);
        drive_item(t_data'(7), 1'b0);
        drive_item(DATA_MAX, 1'b1);

        set_idx = 0;
        sent    = 0;
        while (sent < RANDOM_ITEMS) begin
            // set length: an exactly full set and an overflowing set first, then mostly small
            roll = $urandom_range(0, 99);
            if (set_idx == 0 || set_idx == 6)
                len = CAPACITY;
            else if (set_idx == 1)
                len = CAPACITY + 3;
            else if (roll < 60)
                len = $urandom_range(1, 8);
            else if (roll < 85)
                len = $urandom_range(9, CAPACITY - 1);
            else if (roll < 93)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 6);

            roll = $urandom_range(0, 99);
            mix  = (roll < 50) ? VAL_WIDE : (roll < 80) ? VAL_CLUSTERED : VAL_EDGES;

            // run a stretch of sets with no idling on either side
            in_idle_en  = !(set_idx >= 10 && set_idx < 16);
            out_idle_en = in_idle_en;

            // hold the sink off, starting as this set is offered
            if (set_idx == 6)
                hold_req = 1'b1;
            // let every owed result arrive before starting this set
            if (set_idx == 20)
                wait_results_drained();

            for (k = 0; k < len; k++) begin
                drive_item(pick_value(mix), k == len - 1);
            end
            sent += len;
            set_idx++;
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/msort_pkg.sv
hw/rtl/msort_in_if.sv
hw/rtl/msort_out_if.sv
hw/rtl/msort_ram.sv
hw/rtl/merge_sorter_core.sv
tb/msort_checker.sv
tb/merge_sorter_core_tb.sv
